@@ rtl/ctt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctt_pkg: shared types and constants of the config text tokenizer
// Lexer state codes, event kinds, character constants and the queue entry
// that passes from the lexer front to the result back end.
// ----------------------------------------------------------------------------
package ctt_pkg;

  // Lexer states
  typedef enum logic [2:0] {
    LEX_START = 3'd0,
    LEX_TOKEN = 3'd1,
    LEX_SLASH = 3'd2,
    LEX_LINE  = 3'd3,
    LEX_BLOCK = 3'd4,
    LEX_STAR  = 3'd5
  } lex_state_t;

  // Event kinds on the result side
  localparam logic [1:0] EV_CHAR  = 2'd0;
  localparam logic [1:0] EV_TEND  = 2'd1;
  localparam logic [1:0] EV_ERROR = 2'd2;
  localparam logic [1:0] EV_END   = 2'd3;

  // Character codes
  localparam logic [7:0] CH_EOF    = 8'd26;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_EQUAL  = 8'h3d;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_UNDER  = 8'h5f;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5a;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7a;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;

  // One lexer action: a first event, optionally followed by end of input
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] ch;
    logic       end_follows;
  } ctt_entry_t;

  function automatic logic is_sep(input logic [7:0] c);
    return c == CH_COMMA || c == CH_SEMI || c == CH_SPACE || c == CH_TAB ||
           c == CH_LF || c == CH_CR || c == CH_LPAREN || c == CH_RPAREN ||
           c == CH_EQUAL;
  endfunction

  function automatic logic is_ident(input logic [7:0] c);
    return (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_0 && c <= CH_9) ||
           c == CH_PLUS || c == CH_MINUS || c == CH_DOT || c == CH_UNDER;
  endfunction

endpackage

@@ rtl/ctt_lexer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctt_lexer: byte classifier and lexer state machine
// Takes one byte per cycle while accept is high, updates the lexer state
// and hands any events the byte causes to the queue as a single entry.
// ----------------------------------------------------------------------------
module ctt_lexer (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [7:0]         char_code,
  input  logic               end_mark,
  output logic               emit,
  output ctt_pkg::ctt_entry_t entry
);

  ctt_pkg::lex_state_t state, state_next;
  logic [7:0] lc;
  logic       eof;
  logic       sep;
  logic       ident;

  // Lower-case the byte and classify it
  always_comb begin
    lc    = char_code;
    if (char_code >= ctt_pkg::CH_UP_A && char_code <= ctt_pkg::CH_UP_Z) begin
      lc = char_code | 8'h20;
    end
    eof   = end_mark || (char_code == ctt_pkg::CH_EOF);
    sep   = ctt_pkg::is_sep(lc);
    ident = ctt_pkg::is_ident(lc);
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ctt_pkg::LEX_TOKEN: begin
        if (eof || sep || !ident) state_next = ctt_pkg::LEX_START;
      end
      ctt_pkg::LEX_SLASH: begin
        if (eof) state_next = ctt_pkg::LEX_START;
        else if (lc == ctt_pkg::CH_SLASH) state_next = ctt_pkg::LEX_LINE;
        else if (lc == ctt_pkg::CH_STAR) state_next = ctt_pkg::LEX_BLOCK;
        else state_next = ctt_pkg::LEX_START;
      end
      ctt_pkg::LEX_LINE: begin
        if (eof || lc == ctt_pkg::CH_LF) state_next = ctt_pkg::LEX_START;
      end
      ctt_pkg::LEX_BLOCK: begin
        if (eof) state_next = ctt_pkg::LEX_START;
        else if (lc == ctt_pkg::CH_STAR) state_next = ctt_pkg::LEX_STAR;
      end
      ctt_pkg::LEX_STAR: begin
        if (eof || lc == ctt_pkg::CH_SLASH) state_next = ctt_pkg::LEX_START;
        else state_next = ctt_pkg::LEX_BLOCK;
      end
      default: begin
        if (eof || sep) state_next = ctt_pkg::LEX_START;
        else if (ident) state_next = ctt_pkg::LEX_TOKEN;
        else if (lc == ctt_pkg::CH_SLASH) state_next = ctt_pkg::LEX_SLASH;
        else if (lc == ctt_pkg::CH_HASH) state_next = ctt_pkg::LEX_LINE;
        else state_next = ctt_pkg::LEX_START;
      end
    endcase
  end

  // Events caused by the byte
  always_comb begin
    emit              = 1'b0;
    entry.kind        = ctt_pkg::EV_CHAR;
    entry.ch          = 8'd0;
    entry.end_follows = 1'b0;
    unique case (state)
      ctt_pkg::LEX_TOKEN: begin
        emit = 1'b1;
        if (eof) begin
          entry.kind        = ctt_pkg::EV_TEND;
          entry.end_follows = 1'b1;
        end else if (sep) begin
          entry.kind = ctt_pkg::EV_TEND;
        end else if (ident) begin
          entry.ch = lc;
        end else begin
          entry.kind = ctt_pkg::EV_ERROR;
        end
      end
      ctt_pkg::LEX_SLASH: begin
        entry.kind = ctt_pkg::EV_ERROR;
        if (eof) begin
          emit              = 1'b1;
          entry.end_follows = 1'b1;
        end else if (lc != ctt_pkg::CH_SLASH && lc != ctt_pkg::CH_STAR) begin
          emit = 1'b1;
        end
      end
      ctt_pkg::LEX_LINE: begin
        entry.kind = ctt_pkg::EV_END;
        emit       = eof;
      end
      ctt_pkg::LEX_BLOCK, ctt_pkg::LEX_STAR: begin
        entry.kind        = ctt_pkg::EV_ERROR;
        entry.end_follows = 1'b1;
        emit              = eof;
      end
      default: begin
        if (eof) begin
          emit       = 1'b1;
          entry.kind = ctt_pkg::EV_END;
        end else if (sep) begin
          emit = 1'b0;
        end else if (ident) begin
          emit     = 1'b1;
          entry.ch = lc;
        end else if (lc != ctt_pkg::CH_SLASH && lc != ctt_pkg::CH_HASH) begin
          emit       = 1'b1;
          entry.kind = ctt_pkg::EV_ERROR;
        end
      end
    endcase
    if (!accept) emit = 1'b0;
  end

  // Advance the state on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ctt_pkg::LEX_START;
    end else if (accept) begin
      state <= state_next;
    end
  end

endmodule

@@ rtl/ctt_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctt_queue: short queue of lexer actions
// Decouples the lexer from the result side; head entry is read directly.
// ----------------------------------------------------------------------------
module ctt_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr,
  input  ctt_pkg::ctt_entry_t wr_entry,
  input  logic                rd,
  output ctt_pkg::ctt_entry_t rd_entry,
  output logic                full,
  output logic                empty
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  ctt_pkg::ctt_entry_t slots [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_wr;
  logic            do_rd;

  assign full     = (count == CntW'(DEPTH));
  assign empty    = (count == '0);
  assign do_wr    = wr && !full;
  assign do_rd    = rd && !empty;
  assign rd_entry = slots[rd_ptr];

  // Store entries
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      priority if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end else begin
        count <= count;
      end
    end
  end

endmodule

@@ rtl/ctt_emitter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctt_emitter: result word generator
// Unpacks queue entries into an output register, one result word per cycle
// while popped; adds the trailing end-of-input word where an entry asks.
// ----------------------------------------------------------------------------
module ctt_emitter (
  input  logic                clk,
  input  logic                rst,
  input  ctt_pkg::ctt_entry_t q_entry,
  input  logic                q_empty,
  output logic                q_rd,
  input  logic                pop,
  output logic                empty,
  output logic [1:0]          event_kind,
  output logic [7:0]          token_char,
  output logic                last_of_run
);

  logic out_valid;
  logic end_pending;
  logic load;

  assign load  = !out_valid || pop;
  assign q_rd  = load && !end_pending && !q_empty;
  assign empty = !out_valid;

  // Control: output valid and pending end word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      end_pending <= 1'b0;
    end else if (load) begin
      priority if (end_pending) begin
        out_valid   <= 1'b1;
        end_pending <= 1'b0;
      end else if (!q_empty) begin
        out_valid   <= 1'b1;
        end_pending <= q_entry.end_follows;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload of the output register
  always_ff @(posedge clk) begin
    if (load) begin
      if (end_pending) begin
        event_kind  <= ctt_pkg::EV_END;
        token_char  <= 8'd0;
        last_of_run <= 1'b1;
      end else begin
        event_kind  <= q_entry.kind;
        token_char  <= q_entry.ch;
        last_of_run <= !q_entry.end_follows;
      end
    end
  end

endmodule

@@ rtl/config_text_tokenizer_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// config_text_tokenizer_top: streaming lexer for configuration text
// A result word passes through a queue slot, then the output register.
// Throughput: one byte per cycle while not full; one word drains per pop, so
// bytes that cause two words (end of input) back the queue up one slot each.
// Reset: synchronous rst empties the queue and output and sets the lexer to
// its start state.
// ----------------------------------------------------------------------------
module config_text_tokenizer_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] char_code,
  input  logic       end_mark,
  input  logic       pop,
  output logic       empty,
  output logic [1:0] event_kind,
  output logic [7:0] token_char,
  output logic       last_of_run
);

  ctt_pkg::ctt_entry_t lex_entry;
  ctt_pkg::ctt_entry_t head_entry;
  logic                lex_emit;
  logic                q_full;
  logic                q_empty;
  logic                q_rd;

  assign full = q_full;

  // Front: classify bytes and step the lexer
  ctt_lexer u_lexer (
    .clk       (clk),
    .rst       (rst),
    .accept    (push && !q_full),
    .char_code (char_code),
    .end_mark  (end_mark),
    .emit      (lex_emit),
    .entry     (lex_entry)
  );

  // Hold actions between front and back
  ctt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (lex_emit),
    .wr_entry (lex_entry),
    .rd       (q_rd),
    .rd_entry (head_entry),
    .full     (q_full),
    .empty    (q_empty)
  );

  // Back: expand actions into result words
  ctt_emitter u_emitter (
    .clk         (clk),
    .rst         (rst),
    .q_entry     (head_entry),
    .q_empty     (q_empty),
    .q_rd        (q_rd),
    .pop         (pop),
    .empty       (empty),
    .event_kind  (event_kind),
    .token_char  (token_char),
    .last_of_run (last_of_run)
  );

endmodule
